/* rtl/c2csr_pkg.sv */
// Package for the COO to CSR row pointer builder: payload structs, status and
// register index codes, and the fixed limits. No dependencies.
`default_nettype none

package c2csr_pkg;

   localparam int unsigned MAX_ROWS    = 1024;
   localparam int unsigned MAX_COLS    = 1024;
   localparam int unsigned MAX_ENTRIES = 65536;

   localparam int unsigned IDX_W = 10;
   localparam int unsigned REG_W = 11;
   localparam int unsigned CNT_W = 17;
   localparam int unsigned VAL_W = 64;

   // previous row value meaning "no row seen yet in this matrix"
   localparam logic [REG_W-1:0] NO_ROW = '1;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_RUN   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ROW_DEC   = 3'd1,
      ST_COL_ORDER = 3'd2,
      ST_RANGE     = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic             last;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [REG_W-1:0] row_first;
      logic [REG_W-1:0] row_last;
      logic [CNT_W-1:0] pointer;
      logic [IDX_W-1:0] out_column;
      logic [VAL_W-1:0] out_value;
      logic [2:0]       status;
      logic             final_res;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/coo_to_csr_row_pointer_builder.sv */
// Top level of the COO to CSR row pointer builder: input register, result
// sequencing and output register. Depends on c2csr_pkg.
//
// Usage: entries arrive on req_ (row, column, value, last) in coordinate order.
// For each entry the block returns on rsp_, in order: a row pointer run if the
// row advances, the entry result (or an error status if it is dropped), and a
// trailing run closing the matrix if last is set. csr_ writes the row count
// (index 0) and the column count (index 1); it is always ready, and the user
// must write it only while the block is idle; the block does not enforce this.
// An entry passes through the input register and then the output register to
// rsp_. The output register gives one result per cycle while the receiver
// takes them; an entry causes one to three results, and a new entry can be
// taken while the last result of the one before is loaded, so entries with
// one result follow every cycle unless the receiver stalls.
// A stalled receiver holds the output register, then the input register, then
// req_ready drops. Reset clears the valid flags of both registers, the previous
// row, column and entry count, and sets both count registers to 1024.
`default_nettype none

module coo_to_csr_row_pointer_builder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire c2csr_pkg::req_type          req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output c2csr_pkg::rsp_type               rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire c2csr_pkg::csr_index_type    csr_index,
   input  wire logic [c2csr_pkg::REG_W-1:0] csr_data
);
   import c2csr_pkg::*;

   logic [REG_W-1:0] num_rows_ff, num_cols_ff;
   logic [REG_W-1:0] prev_row_ff, prev_row_in;
   logic [IDX_W-1:0] prev_col_ff, prev_col_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             item_valid_ff, item_valid_in;
   req_type          item_ff, item_in;
   logic [1:0]       slot_ff, slot_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [REG_W-1:0] rc, cc;
   logic [REG_W-1:0] row_x, col_x, run_first, tail_prev, tail_first, tail_last;
   logic [CNT_W-1:0] tail_count;
   logic             have, ok, advance, load, done;
   logic [1:0]       sel;
   status_type       status;
   rsp_type          res_run, res_entry, res_tail;

   // clamp registers to 1..max
   always_comb begin
      if (num_rows_ff == '0) begin
         rc = REG_W'(1);
      end else if (num_rows_ff > REG_W'(MAX_ROWS)) begin
         rc = REG_W'(MAX_ROWS);
      end else begin
         rc = num_rows_ff;
      end
      if (num_cols_ff == '0) begin
         cc = REG_W'(1);
      end else if (num_cols_ff > REG_W'(MAX_COLS)) begin
         cc = REG_W'(MAX_COLS);
      end else begin
         cc = num_cols_ff;
      end
   end

   assign row_x = {1'b0, item_ff.row};
   assign col_x = {1'b0, item_ff.column};
   assign have  = (prev_row_ff != NO_ROW);

   always_comb begin
      if (row_x >= rc || col_x >= cc) begin
         status = ST_RANGE;
      end else if (have && row_x < prev_row_ff) begin
         status = ST_ROW_DEC;
      end else if (have && row_x == prev_row_ff && item_ff.column <= prev_col_ff) begin
         status = ST_COL_ORDER;
      end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_OK;
      end
   end

   assign ok        = (status == ST_OK);
   assign advance   = ok && (!have || row_x > prev_row_ff);
   assign run_first = have ? prev_row_ff + REG_W'(1) : '0;

   // state as it stands after this entry, for the trailing run
   assign tail_prev  = ok ? row_x : prev_row_ff;
   assign tail_count = ok ? count_ff + CNT_W'(1) : count_ff;
   assign tail_first = (tail_prev != NO_ROW) ? tail_prev + REG_W'(1) : '0;
   assign tail_last  = (rc >= tail_first) ? rc : tail_first;

   always_comb begin
      res_run            = '0;
      res_run.kind       = KIND_RUN;
      res_run.row_first  = run_first;
      res_run.row_last   = row_x;
      res_run.pointer    = count_ff;

      res_entry            = '0;
      res_entry.kind       = KIND_ENTRY;
      res_entry.status     = status;
      res_entry.out_column = ok ? item_ff.column : '0;
      res_entry.out_value  = ok ? item_ff.value : '0;

      res_tail           = '0;
      res_tail.kind      = KIND_RUN;
      res_tail.row_first = tail_first;
      res_tail.row_last  = tail_last;
      res_tail.pointer   = tail_count;
      res_tail.final_res = 1'b1;
   end

   // slot 0 run, slot 1 entry, slot 2 trailing run; skip an absent run
   assign sel  = (slot_ff == 2'd0 && !advance) ? 2'd1 : slot_ff;
   assign done = (sel == 2'd2) || (sel == 2'd1 && !item_ff.last);
   assign load = item_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign req_ready = !item_valid_ff || (load && done);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      prev_row_in   = prev_row_ff;
      prev_col_in   = prev_col_ff;
      count_in      = count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         case (sel)
            2'd0:    rsp_in = res_run;
            2'd1:    rsp_in = res_entry;
            2'd2:    rsp_in = res_tail;
            default: rsp_in = res_entry;
         endcase
         if (done) begin
            item_valid_in = 1'b0;
            slot_in       = 2'd0;
            if (item_ff.last) begin
               prev_row_in = NO_ROW;
               prev_col_in = '0;
               count_in    = '0;
            end else if (ok) begin
               prev_row_in = row_x;
               prev_col_in = item_ff.column;
               count_in    = count_ff + CNT_W'(1);
            end
         end else begin
            slot_in = sel + 2'd1;
         end
      end

      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
         slot_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff   <= REG_W'(1024);
         num_cols_ff   <= REG_W'(1024);
         prev_row_ff   <= NO_ROW;
         prev_col_ff   <= '0;
         count_ff      <= '0;
         item_valid_ff <= 1'b0;
         slot_ff       <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_ROWS: num_rows_ff <= csr_data;
               CSR_NUM_COLS: num_cols_ff <= csr_data;
               default:      num_rows_ff <= num_rows_ff;
            endcase
         end
         prev_row_ff   <= prev_row_in;
         prev_col_ff   <= prev_col_in;
         count_ff      <= count_in;
         item_valid_ff <= item_valid_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // a final result is always a pointer run
   a_final_is_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_res |-> rsp_data.kind == KIND_RUN)
      else $error("final result that is not a run");

   // closing a matrix clears the tracking state
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      load && done && item_ff.last |=> prev_row_ff == NO_ROW && count_ff == '0)
      else $error("matrix state not cleared after final entry");

   // the entry count never passes the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above limit");

   // the sequencing slot never rests on an absent trailing run
   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && slot_ff == 2'd2 |-> item_ff.last)
      else $error("trailing slot selected without last");

endmodule

`default_nettype wire

/* verif/coo_to_csr_row_pointer_builder_tb.sv */
// Testbench for coo_to_csr_row_pointer_builder: drives sparse entries and count
// registers, predicts every run and entry result, and checks them in order.
// Depends on c2csr_pkg and the block's RTL.
`default_nettype none

module coo_to_csr_row_pointer_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c2csr_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // Expected results of the row pointer builder, kept in arrival order.
   class row_pointer_scoreboard;
      int errors;
      int results_checked;
      int matrices_closed;
      logic [REG_W-1:0] num_rows_reg;
      logic [REG_W-1:0] num_cols_reg;
      logic [REG_W-1:0] prev_row;
      logic [IDX_W-1:0] prev_col;
      logic [CNT_W-1:0] entry_count;
      rsp_type          expected_q[$];

      function new();
         num_rows_reg = REG_W'(MAX_ROWS);
         num_cols_reg = REG_W'(MAX_COLS);
         close_matrix();
      endfunction

      function void close_matrix();
         prev_row    = NO_ROW;
         prev_col    = '0;
         entry_count = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [REG_W-1:0] data);
         if (idx == CSR_NUM_ROWS) begin
            num_rows_reg = data;
         end else begin
            num_cols_reg = data;
         end
      endfunction

      // zero reads as one, anything past the limit reads as the limit
      function int effective(logic [REG_W-1:0] data, int unsigned limit);
         if (data == 0) return 1;
         if (data > limit) return limit;
         return data;
      endfunction

      function void note_entry(req_type e);
         int               rc;
         int               cc;
         bit               have;
         status_type       st;
         rsp_type          r;
         logic [REG_W-1:0] first;
         rc   = effective(num_rows_reg, MAX_ROWS);
         cc   = effective(num_cols_reg, MAX_COLS);
         have = (prev_row != NO_ROW);
         st   = ST_OK;
         if (e.row >= rc || e.column >= cc) begin
            st = ST_RANGE;
         end else if (have && e.row < prev_row) begin
            st = ST_ROW_DEC;
         end else if (have && e.row == prev_row && e.column <= prev_col) begin
            st = ST_COL_ORDER;
         end else if (entry_count >= MAX_ENTRIES) begin
            st = ST_OVERFLOW;
         end

         if (st != ST_OK) begin
            r        = '0;
            r.kind   = KIND_ENTRY;
            r.status = st;
            expected_q.push_back(r);
         end else begin
            if (!have || e.row > prev_row) begin
               r           = '0;
               r.kind      = KIND_RUN;
               r.row_first = have ? prev_row + 11'd1 : 11'd0;
               r.row_last  = REG_W'(e.row);
               r.pointer   = entry_count;
               expected_q.push_back(r);
            end
            r            = '0;
            r.kind       = KIND_ENTRY;
            r.out_column = e.column;
            r.out_value  = e.value;
            expected_q.push_back(r);
            prev_row    = REG_W'(e.row);
            prev_col    = e.column;
            entry_count = entry_count + 1'b1;
         end

         // close the matrix even when the final entry itself was dropped
         if (e.last) begin
            first       = (prev_row != NO_ROW) ? prev_row + 11'd1 : 11'd0;
            r           = '0;
            r.kind      = KIND_RUN;
            r.row_first = first;
            r.row_last  = (rc >= first) ? REG_W'(rc) : first;
            r.pointer   = entry_count;
            r.final_res = 1'b1;
            expected_q.push_back(r);
            close_matrix();
            matrices_closed++;
         end
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      function string field_msg(string name, logic [63:0] got, logic [63:0] want);
         return $sformatf("%s got %0h expected %0h", name, got, want);
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind)
            report(field_msg("kind", got.kind, want.kind));
         if (got.row_first !== want.row_first)
            report(field_msg("row_first", got.row_first, want.row_first));
         if (got.row_last !== want.row_last)
            report(field_msg("row_last", got.row_last, want.row_last));
         if (got.pointer !== want.pointer)
            report(field_msg("pointer", got.pointer, want.pointer));
         if (got.out_column !== want.out_column)
            report(field_msg("out_column", got.out_column, want.out_column));
         if (got.out_value !== want.out_value)
            report(field_msg("out_value", got.out_value, want.out_value));
         if (got.status !== want.status)
            report(field_msg("status", got.status, want.status));
         if (got.final_res !== want.final_res)
            report(field_msg("final_res", got.final_res, want.final_res));
      endtask
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_NUM_ROWS;
   logic [REG_W-1:0] csr_data  = '0;

   row_pointer_scoreboard board;
   bit idle_on      = 1'b0;
   int ready_hold   = 0;
   int quiet_cycles = 0;
   int entries_sent = 0;
   int gen_row      = -1;
   int gen_col      = 0;

   coo_to_csr_row_pointer_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver: stall in bursts of random length while idle_on is set
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         ready_hold <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) board.note_entry(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [VAL_W-1:0] rand_value();
      return {$urandom, $urandom};
   endfunction

   task automatic send_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic [VAL_W-1:0] value, input logic is_last);
      req_type e;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      e.row     = row;
      e.column  = col;
      e.value   = value;
      e.last    = is_last;
      req_valid <= 1'b1;
      req_data  <= e;
      do @(posedge clock); while (!(req_valid && req_ready));
      entries_sent++;
   endtask

   // hold the sender until every expected result has come, then settle
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_counts(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols);
      drain(4);
      csr_valid <= 1'b1;
      csr_index <= CSR_NUM_ROWS;
      csr_data  <= rows;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_index <= CSR_NUM_COLS;
      csr_data  <= cols;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed matrices with random shape, some out-of-order and
   // out-of-range entries mixed in
   task automatic random_phase(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols,
                               input int items);
      int eff_rc;
      int eff_cc;
      int row;
      int col;
      bit last;
      bit noisy;
      set_counts(rows, cols);
      eff_rc = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
      eff_cc = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
      repeat (items) begin
         noisy = 1'b0;
         last  = 1'b0;
         if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 2))
               0: if (gen_row >= 0) begin
                  row   = gen_row;
                  col   = gen_col;
                  noisy = 1'b1;
               end
               1: if (gen_row > 0) begin
                  row   = $urandom_range(0, gen_row - 1);
                  col   = $urandom_range(0, 1023);
                  noisy = 1'b1;
               end
               default: if (eff_rc < MAX_ROWS) begin
                  row   = $urandom_range(eff_rc, 1023);
                  col   = $urandom_range(0, 1023);
                  noisy = 1'b1;
               end else if (eff_cc < MAX_COLS) begin
                  row   = $urandom_range(0, 1023);
                  col   = $urandom_range(eff_cc, 1023);
                  noisy = 1'b1;
               end
            endcase
            last = noisy && ($urandom_range(0, 11) == 0);
         end
         if (!noisy) begin
            if (gen_row >= 0 && gen_row >= eff_rc - 1 &&
                (gen_row >= eff_rc || gen_col >= eff_cc - 1)) begin
               // matrix is full: close it with a dropped entry
               row  = gen_row;
               col  = gen_col;
               last = 1'b1;
            end else if (gen_row < 0 || (gen_row < eff_rc - 1 &&
                         ($urandom_range(0, 3) == 0 || gen_col >= eff_cc - 1))) begin
               row = gen_row + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : 0);
               if (row > eff_rc - 1) row = eff_rc - 1;
               if ($urandom_range(0, 15) == 0) row = $urandom_range(gen_row + 1, eff_rc - 1);
               col = $urandom_range(0, (eff_cc > 4) ? 3 : eff_cc - 1);
               if ($urandom_range(0, 15) == 0) col = $urandom_range(0, eff_cc - 1);
               last = ($urandom_range(0, 9) == 0);
            end else begin
               row = gen_row;
               col = gen_col + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 300) : 0);
               if (col > 1023) col = 1023;
               last = ($urandom_range(0, 9) == 0);
            end
            if (row >= eff_rc || col >= eff_cc) last = 1'b1;
         end
         send_entry(IDX_W'(row), IDX_W'(col), rand_value(), last);
         if (last) begin
            gen_row = -1;
         end else if (!noisy) begin
            gen_row = row;
            gen_col = col;
         end
      end
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // reset counts: 1024 rows, 1024 columns
      send_entry(10'd0, 10'd0, '0, 1'b0);
      send_entry(10'd0, 10'd1023, '1, 1'b0);
      send_entry(10'd0, 10'd1023, rand_value(), 1'b0);  // repeated column
      send_entry(10'd0, 10'd5, rand_value(), 1'b0);     // column goes back
      send_entry(10'd3, 10'd2, rand_value(), 1'b0);     // rows 1 and 2 empty
      send_entry(10'd1, 10'd0, rand_value(), 1'b0);     // row goes back
      send_entry(10'd1023, 10'd1023, rand_value(), 1'b0);
      send_entry(10'd1023, 10'd1023, rand_value(), 1'b1);  // dropped final entry
      send_entry(10'd5, 10'd7, rand_value(), 1'b1);     // run, entry and trailing run
      set_counts(11'd4, 11'd8);
      send_entry(10'd4, 10'd0, rand_value(), 1'b0);
      send_entry(10'd0, 10'd8, rand_value(), 1'b0);
      send_entry(10'd2, 10'd7, rand_value(), 1'b0);
      send_entry(10'd3, 10'd0, rand_value(), 1'b1);
      send_entry(10'd9, 10'd1, rand_value(), 1'b1);     // empty matrix
      set_counts(11'd0, 11'd2047);
      send_entry(10'd0, 10'd1023, rand_value(), 1'b0);
      send_entry(10'd1, 10'd0, rand_value(), 1'b1);
      set_counts(11'd1024, 11'd1);
      send_entry(10'd1023, 10'd0, rand_value(), 1'b1);
      set_counts(11'd1024, 11'd1024);
      send_entry(10'd500, 10'd3, rand_value(), 1'b0);
      set_counts(11'd100, 11'd1024);                    // lower rows below open matrix
      send_entry(10'd500, 10'd4, rand_value(), 1'b1);

      random_phase(11'd1024, 11'd1024, 43);
      random_phase(11'd1, 11'd1024, 43);
      random_phase(11'd1024, 11'd1, 43);
      random_phase(11'd4, 11'd4, 43);
      random_phase(11'd0, 11'd2047, 43);
      random_phase(11'd2047, 11'd0, 43);
      random_phase(REG_W'($urandom_range(1, 64)), REG_W'($urandom_range(1, 64)), 43);
      random_phase(REG_W'($urandom_range(1, 1024)), REG_W'($urandom_range(1, 1024)), 43);
      idle_on = 1'b0;
      random_phase(11'd1024, 11'd1024, 43);

      drain(8);
      $display("Summary: %0d entries sent, %0d results checked, %0d matrices closed",
               entries_sent, board.results_checked, board.matrices_closed);
      $display("Summary: corner entries, dropped final entries and a spread of count settings");
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
